### rtl/cau_pkg.sv
// Shared constants and pipeline payload types for the complex arithmetic unit.
// Used by every module of the block; has no dependencies of its own.
`timescale 1ns / 1ps

package cau_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 8;

  // Magnitude width of a product or of a sum of two products.
  localparam int PW    = 2 * DATA_WIDTH;
  // Quotient bits needed below the saturation point.
  localparam int QW    = DATA_WIDTH + 1;
  // Partial remainder width of the restoring divider.
  localparam int RW    = PW + DATA_WIDTH + 1;
  localparam int NSTEP = QW;

  localparam logic [1:0] KIND_ADD = 2'd0;
  localparam logic [1:0] KIND_SUB = 2'd1;
  localparam logic [1:0] KIND_MUL = 2'd2;
  localparam logic [1:0] KIND_DIV = 2'd3;

  typedef struct packed {
    logic          neg;
    logic [PW-1:0] mag;
    logic          ovf;
    logic [RW-1:0] rem;
    logic [QW-1:0] q;
  } lane_t;

  typedef struct packed {
    logic [1:0]    kind;
    logic          dz;
    logic [PW-1:0] d;
    lane_t         re;
    lane_t         im;
  } dpipe_t;

endpackage

### rtl/complex_arith_unit.sv
// Complex-number ALU: add, subtract, multiply, divide on signed Q8.8 operands.
// The pipeline has three front stages, seventeen divider stages and one output stage.
// Throughput is one beat per cycle; the whole pipeline holds while the output is stalled.
// Synchronous active-high reset clears the valid bits; payload registers are not reset.
// Depends on cau_pkg, cau_front, cau_divider and cau_back.
`timescale 1ns / 1ps

module complex_arith_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 req_valid,
  output logic                                 req_ready,
  input  logic [1:0]                           kind,
  input  logic signed [cau_pkg::DATA_WIDTH-1:0] a_real,
  input  logic signed [cau_pkg::DATA_WIDTH-1:0] a_imag,
  input  logic signed [cau_pkg::DATA_WIDTH-1:0] b_real,
  input  logic signed [cau_pkg::DATA_WIDTH-1:0] b_imag,
  output logic                                 rsp_valid,
  input  logic                                 rsp_ready,
  output logic signed [cau_pkg::DATA_WIDTH-1:0] res_real,
  output logic signed [cau_pkg::DATA_WIDTH-1:0] res_imag,
  output logic                                 saturated,
  output logic                                 divide_by_zero
);

  localparam int DW = cau_pkg::DATA_WIDTH;

  logic            en;
  logic            fv, dv;
  cau_pkg::dpipe_t fd, dd;

  assign en        = !rsp_valid || rsp_ready;
  assign req_ready = en;

  cau_front u_front (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .valid_i (req_valid),
    .kind    (kind),
    .a_real  (a_real),
    .a_imag  (a_imag),
    .b_real  (b_real),
    .b_imag  (b_imag),
    .valid_o (fv),
    .data_o  (fd)
  );

  cau_divider u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .valid_i (fv),
    .data_i  (fd),
    .valid_o (dv),
    .data_o  (dd)
  );

  cau_back u_back (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .valid_i        (dv),
    .data_i         (dd),
    .valid_o        (rsp_valid),
    .res_real       (res_real),
    .res_imag       (res_imag),
    .saturated      (saturated),
    .divide_by_zero (divide_by_zero)
  );

  localparam logic [DW-1:0] MAXW = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] MINW = {1'b1, {(DW-1){1'b0}}};

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && divide_by_zero |-> res_real == '0 && res_imag == '0 && !saturated)
    else $error("divide by zero result is not zero");

  a_sat_edge: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && saturated |-> $unsigned(res_real) == MAXW || $unsigned(res_real) == MINW ||
                               $unsigned(res_imag) == MAXW || $unsigned(res_imag) == MINW)
    else $error("saturated flag without a clipped part");

  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("output valid after reset");

endmodule

### rtl/cau_front.sv
// Front end: operand products, sum forming, sign-magnitude split and divider setup.
// Three register stages; depends on cau_pkg.
`timescale 1ns / 1ps

module cau_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 valid_i,
  input  logic [1:0]                           kind,
  input  logic signed [cau_pkg::DATA_WIDTH-1:0] a_real,
  input  logic signed [cau_pkg::DATA_WIDTH-1:0] a_imag,
  input  logic signed [cau_pkg::DATA_WIDTH-1:0] b_real,
  input  logic signed [cau_pkg::DATA_WIDTH-1:0] b_imag,
  output logic                                 valid_o,
  output cau_pkg::dpipe_t                      data_o
);

  localparam int DW = cau_pkg::DATA_WIDTH;
  localparam int PW = cau_pkg::PW;
  localparam int RW = cau_pkg::RW;

  logic                 v1, v2;
  logic [1:0]           k1, k2;
  logic signed [DW:0]   sr1, si1;
  logic signed [PW-1:0] p_rr, p_ii, p_ir, p_ri, q_rr, q_ii;

  logic signed [PW:0]   re_s, im_s;
  logic                 re_neg2, im_neg2;
  logic [PW-1:0]        re_mag2, im_mag2, d2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      v2      <= 1'b0;
      valid_o <= 1'b0;
    end else if (en) begin
      v1      <= valid_i;
      v2      <= v1;
      valid_o <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k1 <= kind;
      if (kind == cau_pkg::KIND_SUB) begin
        sr1 <= (DW+1)'(a_real) - (DW+1)'(b_real);
        si1 <= (DW+1)'(a_imag) - (DW+1)'(b_imag);
      end else begin
        sr1 <= (DW+1)'(a_real) + (DW+1)'(b_real);
        si1 <= (DW+1)'(a_imag) + (DW+1)'(b_imag);
      end
      p_rr <= a_real * b_real;
      p_ii <= a_imag * b_imag;
      p_ir <= a_imag * b_real;
      p_ri <= a_real * b_imag;
      q_rr <= b_real * b_real;
      q_ii <= b_imag * b_imag;
    end
  end

  always_comb begin
    case (k1)
      cau_pkg::KIND_MUL: begin
        re_s = (PW+1)'(p_rr) - (PW+1)'(p_ii);
        im_s = (PW+1)'(p_ir) + (PW+1)'(p_ri);
      end
      cau_pkg::KIND_DIV: begin
        re_s = (PW+1)'(p_rr) + (PW+1)'(p_ii);
        im_s = (PW+1)'(p_ir) - (PW+1)'(p_ri);
      end
      default: begin
        re_s = (PW+1)'(sr1);
        im_s = (PW+1)'(si1);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k2      <= k1;
      re_neg2 <= re_s[PW];
      im_neg2 <= im_s[PW];
      re_mag2 <= re_s[PW] ? PW'(-re_s) : PW'(re_s);
      im_mag2 <= im_s[PW] ? PW'(-im_s) : PW'(im_s);
      d2      <= $unsigned(q_rr) + $unsigned(q_ii);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_o.kind   <= k2;
      data_o.dz     <= (d2 == '0);
      data_o.d      <= d2;
      data_o.re.neg <= re_neg2;
      data_o.re.mag <= re_mag2;
      data_o.re.ovf <= RW'(re_mag2) >= (RW'(d2) << (DW - cau_pkg::FRAC_BITS));
      data_o.re.rem <= RW'(re_mag2) << (cau_pkg::FRAC_BITS + 1);
      data_o.re.q   <= '0;
      data_o.im.neg <= im_neg2;
      data_o.im.mag <= im_mag2;
      data_o.im.ovf <= RW'(im_mag2) >= (RW'(d2) << (DW - cau_pkg::FRAC_BITS));
      data_o.im.rem <= RW'(im_mag2) << (cau_pkg::FRAC_BITS + 1);
      data_o.im.q   <= '0;
    end
  end

endmodule

### rtl/cau_divider.sv
// Pipelined restoring divider: one quotient bit per stage for both result parts.
// Depends on cau_pkg.
`timescale 1ns / 1ps

module cau_divider (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            valid_i,
  input  cau_pkg::dpipe_t data_i,
  output logic            valid_o,
  output cau_pkg::dpipe_t data_o
);

  localparam int NSTEP = cau_pkg::NSTEP;
  localparam int RW    = cau_pkg::RW;

  logic            vld_w [NSTEP+1];
  cau_pkg::dpipe_t dat_w [NSTEP+1];

  assign vld_w[0] = valid_i;
  assign dat_w[0] = data_i;

  for (genvar s = 0; s < NSTEP; s++) begin : g_step
    localparam int K = NSTEP - 1 - s;
    logic            vld;
    cau_pkg::dpipe_t dat, nxt;
    logic [RW-1:0]   dk;

    always_comb begin
      nxt = dat_w[s];
      dk  = RW'(dat_w[s].d) << K;
      if (dat_w[s].re.rem >= dk) begin
        nxt.re.rem  = dat_w[s].re.rem - dk;
        nxt.re.q[K] = 1'b1;
      end
      if (dat_w[s].im.rem >= dk) begin
        nxt.im.rem  = dat_w[s].im.rem - dk;
        nxt.im.q[K] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld <= 1'b0;
      end else if (en) begin
        vld <= vld_w[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dat <= nxt;
      end
    end

    assign vld_w[s+1] = vld;
    assign dat_w[s+1] = dat;
  end

  assign valid_o = vld_w[NSTEP];
  assign data_o  = dat_w[NSTEP];

endmodule

### rtl/cau_back.sv
// Back end: rounding, saturation and the output register.
// Depends on cau_pkg.
`timescale 1ns / 1ps

module cau_back (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 valid_i,
  input  cau_pkg::dpipe_t                      data_i,
  output logic                                 valid_o,
  output logic signed [cau_pkg::DATA_WIDTH-1:0] res_real,
  output logic signed [cau_pkg::DATA_WIDTH-1:0] res_imag,
  output logic                                 saturated,
  output logic                                 divide_by_zero
);

  localparam int DW = cau_pkg::DATA_WIDTH;
  localparam int PW = cau_pkg::PW;
  localparam logic [PW:0] HALF = (PW+1)'((2 ** cau_pkg::FRAC_BITS) / 2);
  localparam logic [PW:0] LIM  = (PW+1)'(1) << (DW - 1);

  function automatic logic [PW:0] lane_mag(logic [1:0] k, cau_pkg::lane_t l);
    logic [PW:0] m;
    case (k)
      cau_pkg::KIND_MUL: m = ((PW+1)'(l.mag) + HALF) >> cau_pkg::FRAC_BITS;
      cau_pkg::KIND_DIV: m = l.ovf ? LIM + (PW+1)'(1) : ((PW+1)'(l.q) + (PW+1)'(1)) >> 1;
      default:           m = (PW+1)'(l.mag);
    endcase
    return m;
  endfunction

  function automatic logic [DW:0] sat(logic neg, logic [PW:0] m);
    logic [DW:0] r;
    if (neg) begin
      if (m > LIM) r = {1'b1, DW'(LIM)};
      else         r = {1'b0, DW'(-m)};
    end else begin
      if (m > LIM - (PW+1)'(1)) r = {1'b1, DW'(LIM - (PW+1)'(1))};
      else                      r = {1'b0, DW'(m)};
    end
    return r;
  endfunction

  logic [DW:0] sre, sim;

  always_comb begin
    sre = sat(data_i.re.neg, lane_mag(data_i.kind, data_i.re));
    sim = sat(data_i.im.neg, lane_mag(data_i.kind, data_i.im));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_o <= 1'b0;
    end else if (en) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (data_i.kind == cau_pkg::KIND_DIV && data_i.dz) begin
        res_real       <= '0;
        res_imag       <= '0;
        saturated      <= 1'b0;
        divide_by_zero <= 1'b1;
      end else begin
        res_real       <= sre[DW-1:0];
        res_imag       <= sim[DW-1:0];
        saturated      <= sre[DW] | sim[DW];
        divide_by_zero <= 1'b0;
      end
    end
  end

endmodule

### tb/sv/tb.sv
// Self-checking testbench for complex_arith_unit: directed and random beats of all four
// operations, predicted by an in-bench fixed-point model and checked field by field.
// Depends on cau_pkg and the complex_arith_unit RTL.
`timescale 1ns / 1ps

module tb;

  typedef struct {
    logic signed [15:0] re;
    logic signed [15:0] im;
    logic               sat;
    logic               dz;
  } cplx_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  logic [1:0] kind = cau_pkg::KIND_ADD;
  logic signed [15:0] a_real = '0, a_imag = '0, b_real = '0, b_imag = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  logic signed [15:0] res_real, res_imag;
  logic saturated, divide_by_zero;

  cplx_res_t pending_q[$];
  int mismatches = 0;
  int beats_sent = 0;
  int beats_checked = 0;
  int burst_left = 0;
  bit stall_free = 1'b0;

  complex_arith_unit dut (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic longint round_half_away(longint v);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + 128) >>> 8;
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint div_q8(longint n, longint d);
    longint m, q, r;
    m = (n < 0) ? -n : n;
    q = m / d;
    r = m % d;
    if (q > (longint'(1) << 40)) q = longint'(1) << 40;
    for (int i = 0; i <= 8; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q = q | 1;
      end
    end
    m = (q + 1) >>> 1;
    return (n < 0) ? -m : m;
  endfunction

  function automatic logic signed [15:0] clip16(longint v, inout logic sat);
    if (v > 32767) begin
      sat = 1'b1;
      return 16'sd32767;
    end
    if (v < -32768) begin
      sat = 1'b1;
      return -16'sd32768;
    end
    return v[15:0];
  endfunction

  function automatic cplx_res_t predict_alu(logic [1:0] k, longint ar, longint ai,
                                            longint br, longint bi);
    cplx_res_t r;
    longint re, im, d;
    r.sat = 1'b0;
    r.dz = 1'b0;
    case (k)
      cau_pkg::KIND_ADD: begin
        re = ar + br;
        im = ai + bi;
      end
      cau_pkg::KIND_SUB: begin
        re = ar - br;
        im = ai - bi;
      end
      cau_pkg::KIND_MUL: begin
        re = round_half_away(ar * br - ai * bi);
        im = round_half_away(ai * br + ar * bi);
      end
      default: begin
        d = br * br + bi * bi;
        if (d == 0) begin
          r.re = '0;
          r.im = '0;
          r.dz = 1'b1;
          return r;
        end
        re = div_q8(ar * br + ai * bi, d);
        im = div_q8(ai * br - ar * bi, d);
      end
    endcase
    r.re = clip16(re, r.sat);
    r.im = clip16(im, r.sat);
    return r;
  endfunction

  task automatic send_beat(logic [1:0] k, logic [15:0] ar, logic [15:0] ai,
                           logic [15:0] br, logic [15:0] bi);
    int gap;
    while (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_valid <= 1'b1;
    kind <= k;
    a_real <= ar;
    a_imag <= ai;
    b_real <= br;
    b_imag <= bi;
    pending_q.push_back(predict_alu(k, $signed(ar), $signed(ai), $signed(br), $signed(bi)));
    beats_sent++;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if ($urandom_range(0, 199) == 0) stall_free <= ~stall_free;
      rsp_ready <= stall_free ? 1'b1 : ($urandom_range(0, 2) != 0);
    end
  end

  always @(posedge clk) begin
    cplx_res_t exp_r;
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result beat: %0d %0d", res_real, res_imag);
      end else begin
        exp_r = pending_q.pop_front();
        beats_checked++;
        if (res_real !== exp_r.re || res_imag !== exp_r.im || saturated !== exp_r.sat ||
            divide_by_zero !== exp_r.dz) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected %0d %0d sat %b dz %b, got %0d %0d sat %b dz %b",
                     exp_r.re, exp_r.im, exp_r.sat, exp_r.dz,
                     res_real, res_imag, saturated, divide_by_zero);
        end
      end
    end
  end

  function automatic logic [15:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($signed($urandom_range(0, 1023)) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_extremes();
    logic [15:0] vals[4] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
    for (int k = 0; k < 4; k++) begin
      send_beat(k[1:0], vals[k], vals[3 - k], vals[(k + 1) % 4], vals[(k + 2) % 4]);
      send_beat(k[1:0], 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_beat(k[1:0], 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    end
  endtask

  task automatic test_special_cases();
    send_beat(cau_pkg::KIND_DIV, 16'h1234, 16'h8000, 16'h0000, 16'h0000);
    send_beat(cau_pkg::KIND_DIV, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_beat(cau_pkg::KIND_DIV, 16'h7fff, 16'h7fff, 16'h0000, 16'h0001);
    send_beat(cau_pkg::KIND_MUL, 16'h0080, 16'h0000, 16'h0001, 16'h0000);
    send_beat(cau_pkg::KIND_MUL, 16'hff80, 16'h0000, 16'h0001, 16'h0000);
    send_beat(cau_pkg::KIND_DIV, 16'h0100, 16'h0000, 16'h0300, 16'h0000);
    send_beat(cau_pkg::KIND_DIV, 16'h0100, 16'h0100, 16'h0100, 16'hff00);
  endtask

  task automatic drain_pipeline();
    req_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic test_random(int count);
    for (int n = 0; n < count; n++)
      send_beat(2'($urandom_range(0, 3)), rand_operand(), rand_operand(),
                rand_operand(), rand_operand());
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_special_cases();
    drain_pipeline();
    test_random(700);
    drain_pipeline();
    test_random(730);
    drain_pipeline();
    $display("Sent %0d beats over all four operations, extremes, zero divisors included.",
             beats_sent);
    $display("Checked %0d result beats under random stalls on both sides.", beats_checked);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

### files.f
rtl/cau_pkg.sv
rtl/cau_front.sv
rtl/cau_divider.sv
rtl/cau_back.sv
rtl/complex_arith_unit.sv
tb/sv/tb.sv
